### hw/rtl/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg
// Shared types and constants of the connection identity table.
// ----------------------------------------------------------------------------
package cit_pkg;

	// number of connection slots in the table
	localparam int SLOT_COUNT = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// request modes
	localparam logic [1:0] MODE_REGISTER   = 2'd0;
	localparam logic [1:0] MODE_UNREGISTER = 2'd1;
	localparam logic [1:0] MODE_LOOKUP_HDL = 2'd2;
	localparam logic [1:0] MODE_LOOKUP_PSD = 2'd3;

	// request payload
	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] handle;
		logic [47:0] local_addr;
		logic [1:0]  own_addr_type;
		logic [47:0] peer_addr;
		logic [1:0]  remote_addr_type;
		logic [47:0] pseudo_addr;
		logic        id_present;
		logic        pseudo_present;
		logic        link_ready;
	} req_t;

	// response payload
	typedef struct packed {
		logic        ok;
		logic [11:0] found_handle;
		logic [47:0] found_local;
		logic [1:0]  found_own_type;
		logic [47:0] found_peer;
		logic [1:0]  found_remote_type;
		logic [47:0] found_pseudo;
		logic        found_ready;
	} rsp_t;

	// one slot as held in the slot memory (valid bits live in flops)
	typedef struct packed {
		logic [11:0] handle;
		logic [47:0] local_addr;
		logic [1:0]  own_addr_type;
		logic [47:0] peer_addr;
		logic [1:0]  remote_addr_type;
		logic [47:0] pseudo_addr;
		logic        ready;
	} slot_t;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

### hw/rtl/cit_ram.sv
// ----------------------------------------------------------------------------
// cit_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cit_ram #(
	parameter int DEPTH  = 8,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/connection_identity_table.sv
// ----------------------------------------------------------------------------
// connection_identity_table
// Table of connection slots with register, unregister and two lookups.
// ----------------------------------------------------------------------------
// Each request scans every slot of the slot memory through its single read
// port, one slot a cycle from index 0 up, noting the lowest valid slot whose
// key matches and the lowest free slot; the finishing state then writes the
// chosen slot back on a register, clears its valid bit on an unregister and
// loads the response register. A new request is taken while an earlier
// response still waits to be transferred. Valid bits sit in flops cleared by
// reset, so no clearing pass is needed and the table is usable straight
// after reset.
module connection_identity_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cit_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cit_pkg::rsp_t  rsp
);

	localparam logic [cit_pkg::IDX_W-1:0] LAST_IDX = cit_pkg::IDX_W'(cit_pkg::SLOT_COUNT - 1);

	cit_pkg::state_t state_q, state_d;
	cit_pkg::req_t   req_q;
	cit_pkg::rsp_t   rsp_q, rsp_d;
	logic            rsp_valid_q;

	logic [cit_pkg::SLOT_COUNT-1:0] valid_q;

	logic [cit_pkg::IDX_W-1:0] cnt_q;
	logic                      issue_q;
	logic                      beat_s1;
	logic [cit_pkg::IDX_W-1:0] idx_s1;

	logic                      hit_q, free_q;
	logic [cit_pkg::IDX_W-1:0] hit_idx_q, free_idx_q;
	cit_pkg::slot_t            hit_data_q;

	logic                      rd_en, wr_en;
	logic [cit_pkg::IDX_W-1:0] wr_addr;
	cit_pkg::slot_t            rd_data, wr_data;

	logic                      accept, fin_go, key_match, hit_now, free_now;
	logic                      clr_en, set_en;
	logic [cit_pkg::IDX_W-1:0] tgt;

	cit_ram #(
		.DEPTH  (cit_pkg::SLOT_COUNT),
		.WIDTH  ($bits(cit_pkg::slot_t)),
		.ADDR_W (cit_pkg::IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	assign req_ready = (state_q == cit_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign fin_go    = (state_q == cit_pkg::ST_FINISH) && (!rsp_valid_q || rsp_ready);
	assign rd_en     = (state_q == cit_pkg::ST_SCAN) && issue_q;

	// key compare on the slot returned by the memory
	always_comb begin
		if (req_q.mode == cit_pkg::MODE_LOOKUP_PSD) begin
			key_match = (rd_data.pseudo_addr == req_q.pseudo_addr);
		end else begin
			key_match = (rd_data.handle == req_q.handle);
		end
		hit_now  = beat_s1 && valid_q[idx_s1] && key_match && !hit_q;
		free_now = beat_s1 && !valid_q[idx_s1] && !free_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cit_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = cit_pkg::ST_SCAN;
				end
			end
			cit_pkg::ST_SCAN: begin
				if (beat_s1 && idx_s1 == LAST_IDX) begin
					state_d = cit_pkg::ST_FINISH;
				end
			end
			cit_pkg::ST_FINISH: begin
				if (fin_go) begin
					state_d = cit_pkg::ST_IDLE;
				end
			end
			default: state_d = cit_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cit_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// write-back and response build in the finishing cycle
	always_comb begin
		rsp_d   = '0;
		wr_en   = 1'b0;
		clr_en  = 1'b0;
		set_en  = 1'b0;
		tgt     = hit_q ? hit_idx_q : free_idx_q;
		wr_data = hit_q ? hit_data_q : '0;
		wr_data.handle = req_q.handle;
		wr_data.ready  = req_q.link_ready;
		if (req_q.id_present) begin
			wr_data.local_addr       = req_q.local_addr;
			wr_data.own_addr_type    = req_q.own_addr_type;
			wr_data.peer_addr        = req_q.peer_addr;
			wr_data.remote_addr_type = req_q.remote_addr_type;
		end
		if (req_q.pseudo_present) begin
			wr_data.pseudo_addr = req_q.pseudo_addr;
		end
		case (req_q.mode)
			cit_pkg::MODE_REGISTER: begin
				rsp_d.ok = hit_q || free_q;
				wr_en    = fin_go && (hit_q || free_q);
				set_en   = wr_en;
			end
			cit_pkg::MODE_UNREGISTER: begin
				rsp_d.ok = hit_q;
				clr_en   = fin_go && hit_q;
			end
			default: begin
				rsp_d.ok = hit_q;
				if (hit_q) begin
					rsp_d.found_handle      = hit_data_q.handle;
					rsp_d.found_local       = hit_data_q.local_addr;
					rsp_d.found_own_type    = hit_data_q.own_addr_type;
					rsp_d.found_peer        = hit_data_q.peer_addr;
					rsp_d.found_remote_type = hit_data_q.remote_addr_type;
					rsp_d.found_pseudo      = hit_data_q.pseudo_addr;
					rsp_d.found_ready       = hit_data_q.ready;
				end
			end
		endcase
		wr_addr = tgt;
	end

	// scan counter, read pipeline and match tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			beat_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			beat_s1 <= rd_en;
			if (accept) begin
				issue_q <= 1'b1;
				cnt_q   <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					if (cnt_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (free_now) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// payload registers of the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rd_en) begin
			idx_s1 <= cnt_q;
		end
		if (hit_now) begin
			hit_idx_q  <= idx_s1;
			hit_data_q <= rd_data;
		end
		if (free_now) begin
			free_idx_q <= idx_s1;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_en) begin
			valid_q[tgt] <= 1'b1;
		end else if (clr_en) begin
			valid_q[tgt] <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_q <= rsp_d;
		end
	end

	// checks
	a_scan_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_s1 && idx_s1 == LAST_IDX) |=> (state_q == cit_pkg::ST_FINISH))
		else $error("last scan beat did not lead to finish");

	a_register_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |=> valid_q[$past(tgt)])
		else $error("registered slot not valid");

	a_unregister_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |=> !valid_q[$past(tgt)])
		else $error("unregistered slot still valid");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.ok) |-> (rsp_q.found_handle == '0 && rsp_q.found_pseudo == '0
			&& rsp_q.found_local == '0 && rsp_q.found_peer == '0))
		else $error("failed response carries slot data");

endmodule
